FILE: rtl/text_mode_console_writer_top_macros.svh
// ----------------------------------------------------------------------------
// Text mode console writer assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_MODE_CONSOLE_WRITER_TOP_MACROS_SVH

`ifndef SYNTH
`define TMCW_ASSERT_COMB(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("tmcw assertion failed");
`define TMCW_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("tmcw assertion failed");
`else
`define TMCW_ASSERT_COMB(lbl, expr)
`define TMCW_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

FILE: rtl/tmcw_pkg.sv
// ----------------------------------------------------------------------------
// Text mode console writer package
// Screen geometry, character codes, opcodes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmcw_pkg;

  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned TAB_STOP   = 8;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned COPY_CELLS = (ROWS - 1) * COLUMNS;

  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned ADDR_W = $clog2(CELL_COUNT);
  localparam int unsigned POS_W  = 11;
  localparam int unsigned CELL_W = 16;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic       put;
    logic       home;
    logic [7:0] ch;
  } cur_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] pos_next;
    logic             wr_en;
    logic             scroll;
  } cur_stat_t;

endpackage

FILE: rtl/tmcw_screen_ram.sv
// ----------------------------------------------------------------------------
// Screen cell memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmcw_screen_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [tmcw_pkg::ADDR_W-1:0]   waddr_i,
  input  logic [tmcw_pkg::CELL_W-1:0]   wdata_i,
  input  logic                          re_i,
  input  logic [tmcw_pkg::ADDR_W-1:0]   raddr_i,
  output logic [tmcw_pkg::CELL_W-1:0]   rdata_o
);
  import tmcw_pkg::*;

  logic [CELL_W-1:0] mem_q [CELL_COUNT];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tmcw_cursor.sv
// ----------------------------------------------------------------------------
// Cursor unit
// Holds column and row, applies control characters, wrap and scroll.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "text_mode_console_writer_top_macros.svh"

module tmcw_cursor (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tmcw_pkg::cur_cmd_t    cmd_i,
  output tmcw_pkg::cur_stat_t   stat_o
);
  import tmcw_pkg::*;

  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W:0]   col_n;
  logic [ROW_W:0]   row_n;
  logic             wr_en;
  logic             scroll;

  always_comb begin
    col_n  = {1'b0, col_q};
    row_n  = {1'b0, row_q};
    wr_en  = 1'b0;
    scroll = 1'b0;
    if (cmd_i.put) begin
      priority if (cmd_i.ch == CH_BS) begin
        if (col_q != '0) begin
          col_n = col_n - 1'b1;
        end
      end else if (cmd_i.ch == CH_TAB) begin
        col_n = (col_n & ~(COL_W+1)'(TAB_STOP - 1)) + (COL_W+1)'(TAB_STOP);
      end else if (cmd_i.ch == CH_CR) begin
        col_n = '0;
      end else if (cmd_i.ch == CH_LF) begin
        col_n = '0;
        row_n = row_n + 1'b1;
      end else if (cmd_i.ch >= CH_SPACE && cmd_i.ch <= CH_DEL) begin
        wr_en = 1'b1;
        col_n = col_n + 1'b1;
      end else begin
        col_n = {1'b0, col_q};
      end
      if (col_n >= (COL_W+1)'(COLUMNS)) begin
        col_n = '0;
        row_n = row_n + 1'b1;
      end
      if (row_n >= (ROW_W+1)'(ROWS)) begin
        scroll = 1'b1;
        row_n  = (ROW_W+1)'(ROWS - 1);
      end
    end
    if (cmd_i.home) begin
      col_n = '0;
      row_n = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.put || cmd_i.home) begin
      col_q <= col_n[COL_W-1:0];
      row_q <= row_n[ROW_W-1:0];
    end
  end

  assign stat_o.pos      = POS_W'(row_q) * POS_W'(COLUMNS) + POS_W'(col_q);
  assign stat_o.pos_next = POS_W'(row_n) * POS_W'(COLUMNS) + POS_W'(col_n);
  assign stat_o.wr_en    = wr_en;
  assign stat_o.scroll   = scroll;

  `TMCW_ASSERT_COMB(a_col_range, col_q < COL_W'(COLUMNS))
  `TMCW_ASSERT_COMB(a_row_range, row_q < ROW_W'(ROWS))

endmodule

FILE: rtl/tmcw_ctrl.sv
// ----------------------------------------------------------------------------
// Console control
// Item decode, screen sweep for scroll, clear and reset, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "text_mode_console_writer_top_macros.svh"

module tmcw_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [1:0]                    opcode_i,
  input  logic [7:0]                    char_code_i,
  input  logic [3:0]                    bg_color_i,
  input  logic [3:0]                    fg_color_i,
  input  logic [10:0]                   cell_index_i,
  output tmcw_pkg::cur_cmd_t            cur_cmd_o,
  input  tmcw_pkg::cur_stat_t           cur_stat_i,
  output logic                          ram_we_o,
  output logic [tmcw_pkg::ADDR_W-1:0]   ram_waddr_o,
  output logic [tmcw_pkg::CELL_W-1:0]   ram_wdata_o,
  output logic                          ram_re_o,
  output logic [tmcw_pkg::ADDR_W-1:0]   ram_raddr_o,
  input  logic [tmcw_pkg::CELL_W-1:0]   ram_rdata_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [tmcw_pkg::POS_W-1:0]    m_pos_o,
  output logic [tmcw_pkg::CELL_W-1:0]   m_cell_o
);
  import tmcw_pkg::*;

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  sweep_q, sweep_d;
  logic               copy_q, copy_d;
  logic               item_q, item_d;
  logic               oob_q, oob_d;
  logic               stg_vld_q, stg_vld_d;
  logic [ADDR_W-1:0]  stg_addr_q, stg_addr_d;
  logic               stg_blank_q, stg_blank_d;
  logic               out_vld_q;
  logic [POS_W-1:0]   out_pos_q, out_pos_d;
  logic [CELL_W-1:0]  out_cell_q, out_cell_d;
  logic               out_load;
  logic               accept;
  logic               put_wr;
  logic               in_range;

  assign s_ready_o = (state_q == ST_IDLE) && (!out_vld_q || m_ready_i);
  assign accept    = s_valid_i && s_ready_o;
  assign in_range  = cell_index_i < POS_W'(CELL_COUNT);

  assign cur_cmd_o = '{put:  accept && (opcode_i == OP_PUT),
                       home: accept && (opcode_i == OP_CLEAR),
                       ch:   char_code_i};

  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    copy_d      = copy_q;
    item_d      = item_q;
    oob_d       = oob_q;
    stg_vld_d   = 1'b0;
    stg_addr_d  = stg_addr_q;
    stg_blank_d = stg_blank_q;
    out_load    = 1'b0;
    out_pos_d   = out_pos_q;
    out_cell_d  = out_cell_q;
    put_wr      = 1'b0;
    ram_we_o    = stg_vld_q;
    ram_waddr_o = stg_addr_q;
    ram_wdata_o = stg_blank_q ? BLANK_CELL : ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = cell_index_i[ADDR_W-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            OP_PUT: begin
              if (cur_stat_i.wr_en) begin
                put_wr      = 1'b1;
                ram_we_o    = 1'b1;
                ram_waddr_o = cur_stat_i.pos[ADDR_W-1:0];
                ram_wdata_o = {bg_color_i, fg_color_i, char_code_i};
              end
              if (cur_stat_i.scroll) begin
                state_d = ST_SWEEP;
                sweep_d = '0;
                copy_d  = 1'b1;
                item_d  = 1'b1;
              end else begin
                out_load  = 1'b1;
                out_pos_d = cur_stat_i.pos_next;
                out_cell_d = '0;
              end
            end
            OP_CLEAR: begin
              state_d = ST_SWEEP;
              sweep_d = '0;
              copy_d  = 1'b0;
              item_d  = 1'b1;
            end
            OP_READ: begin
              ram_re_o = in_range;
              oob_d    = !in_range;
              state_d  = ST_READ;
            end
            default: begin
              out_load   = 1'b1;
              out_pos_d  = cur_stat_i.pos;
              out_cell_d = '0;
            end
          endcase
        end
      end
      ST_READ: begin
        out_load   = 1'b1;
        out_pos_d  = cur_stat_i.pos;
        out_cell_d = oob_q ? '0 : ram_rdata_i;
        state_d    = ST_IDLE;
      end
      ST_SWEEP: begin
        stg_vld_d  = 1'b1;
        stg_addr_d = sweep_q;
        if (copy_q && sweep_q < ADDR_W'(COPY_CELLS)) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = sweep_q + ADDR_W'(COLUMNS);
          stg_blank_d = 1'b0;
        end else begin
          stg_blank_d = 1'b1;
        end
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == ADDR_W'(CELL_COUNT - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (item_q) begin
          out_load   = 1'b1;
          out_pos_d  = cur_stat_i.pos;
          out_cell_d = '0;
        end
        item_d  = 1'b0;
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_SWEEP;
      sweep_q   <= '0;
      copy_q    <= 1'b0;
      item_q    <= 1'b0;
      oob_q     <= 1'b0;
      stg_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      copy_q    <= copy_d;
      item_q    <= item_d;
      oob_q     <= oob_d;
      stg_vld_q <= stg_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stg_addr_q  <= stg_addr_d;
    stg_blank_q <= stg_blank_d;
    out_pos_q   <= out_pos_d;
    out_cell_q  <= out_cell_d;
  end

  assign m_valid_o = out_vld_q;
  assign m_pos_o   = out_pos_q;
  assign m_cell_o  = out_cell_q;

  `TMCW_ASSERT_COMB(a_one_writer, !(put_wr && stg_vld_q))
  `TMCW_ASSERT_COMB(a_no_overwrite, !out_load || !out_vld_q || m_ready_i)
  `TMCW_ASSERT_COMB(a_stage_idle, !(state_q == ST_IDLE && stg_vld_q))
  `TMCW_ASSERT_NEXT(a_drain_idle, state_q == ST_DRAIN, state_q == ST_IDLE)

endmodule

FILE: rtl/text_mode_console_writer_top.sv
// ----------------------------------------------------------------------------
// Text mode console writer
// 80x25 screen of 16-bit cells with cursor, control characters and scroll.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one command word: tuser is the opcode (put, clear,
//   read), tdata carries character, colors and cell index. Master channel
//   returns one word per command: cursor position and read cell data.
//   Put and ignored commands give their word the cycle after accept; a read
//   passes its cell through the memory read register and then the output
//   register. A put that scrolls and a clear sweep the screen memory, one
//   cell a cycle through a read and a staged write.
//   Throughput: one put per cycle while no scroll happens and the output is
//   taken; a read blocks the next command until its word is loaded; the
//   one-cell-a-cycle screen sweep sets the scroll and clear time.
//   Reset: cursor homes; a sweep with s_axis_tready low blanks screen memory.
//   Stall: the result sits in an output register; a new command is taken
//   only in the cycle that register is empty or being taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_mode_console_writer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  // char_code[7:0], bg_color[11:8], fg_color[15:12], cell_index[26:16], zero[31:27]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cursor_position[10:0], cell_data[26:11], zero[31:27]
  output logic [31:0] m_axis_tdata
);
  import tmcw_pkg::*;

  cur_cmd_t           cur_cmd;
  cur_stat_t          cur_stat;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;
  logic [POS_W-1:0]   out_pos;
  logic [CELL_W-1:0]  out_cell;

  tmcw_screen_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tmcw_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cur_cmd),
    .stat_o (cur_stat)
  );

  tmcw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .opcode_i     (s_axis_tuser),
    .char_code_i  (s_axis_tdata[7:0]),
    .bg_color_i   (s_axis_tdata[11:8]),
    .fg_color_i   (s_axis_tdata[15:12]),
    .cell_index_i (s_axis_tdata[26:16]),
    .cur_cmd_o    (cur_cmd),
    .cur_stat_i   (cur_stat),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_pos_o      (out_pos),
    .m_cell_o     (out_cell)
  );

  assign m_axis_tdata = {(OUT_DATA_W - POS_W - CELL_W)'(0), out_cell, out_pos};

endmodule

FILE: tb/sv/text_mode_console_writer_top_test.sv
// ----------------------------------------------------------------------------
// Text mode console writer testbench
// Streams put, clear, read and unused commands into the console, predicts the
// screen and cursor in a local shadow, and checks every returned word against
// it while the stream sides idle and stall at random, apart and together.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_mode_console_writer_top_test;

  import tmcw_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 10000;
  localparam int unsigned DRAIN_CYCLES = CELL_COUNT + 100;
  localparam int unsigned PHASE_WORDS = 85;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  ch;
    logic [3:0]  back;
    logic [3:0]  fore;
    logic [10:0] index;
  } console_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] cdata;
  } console_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  console_cmd_t cmd_pend_q[$];
  console_res_t console_expect_q[$];
  console_cmd_t cur_cmd;

  logic [CELL_W-1:0] shadow_screen [CELL_COUNT];
  int shadow_col;
  int shadow_row;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int stim_count = 0;
  int unsigned quiet_cycles = 0;

  text_mode_console_writer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void blank_shadow();
    for (int i = 0; i < CELL_COUNT; i++) shadow_screen[i] = BLANK_CELL;
    shadow_col = 0;
    shadow_row = 0;
  endfunction

  function automatic console_res_t console_step(console_cmd_t c);
    console_res_t r;
    r.cdata = '0;
    if (c.op == OP_PUT) begin
      if (c.ch == CH_BS) begin
        if (shadow_col > 0) shadow_col--;
      end else if (c.ch == CH_TAB) begin
        shadow_col = shadow_col + TAB_STOP - (shadow_col % TAB_STOP);
      end else if (c.ch == CH_CR) begin
        shadow_col = 0;
      end else if (c.ch == CH_LF) begin
        shadow_col = 0;
        shadow_row++;
      end else if (c.ch >= CH_SPACE && c.ch <= CH_DEL) begin
        shadow_screen[shadow_row * COLUMNS + shadow_col] = {c.back, c.fore, c.ch};
        shadow_col++;
      end
      if (shadow_col >= COLUMNS) begin
        shadow_col = 0;
        shadow_row++;
      end
      if (shadow_row >= ROWS) begin
        for (int i = 0; i < COPY_CELLS; i++) shadow_screen[i] = shadow_screen[i + COLUMNS];
        for (int i = COPY_CELLS; i < CELL_COUNT; i++) shadow_screen[i] = BLANK_CELL;
        shadow_row = ROWS - 1;
      end
    end else if (c.op == OP_CLEAR) begin
      blank_shadow();
    end else if (c.op == OP_READ) begin
      if (c.index < CELL_COUNT) r.cdata = shadow_screen[c.index];
    end
    r.pos = POS_W'(shadow_row * COLUMNS + shadow_col);
    return r;
  endfunction

  task automatic push_put(input logic [7:0] ch, input logic [3:0] back,
                          input logic [3:0] fore);
    console_cmd_t c;
    c.op = OP_PUT;
    c.ch = ch;
    c.back = back;
    c.fore = fore;
    c.index = 11'($urandom_range(2047));
    cmd_pend_q.push_back(c);
    if (ch < 8'h80) stim_count++;
  endtask

  task automatic push_op(input logic [1:0] op, input int idx);
    console_cmd_t c;
    c.op = op;
    c.ch = 8'($urandom_range(255));
    c.back = 4'($urandom_range(15));
    c.fore = 4'($urandom_range(15));
    c.index = 11'(idx);
    cmd_pend_q.push_back(c);
    if (op != OP_UNUSED) stim_count++;
  endtask

  function automatic int pick_cell_index();
    int r;
    r = $urandom_range(99);
    if (r < 45) return $urandom_range(CELL_COUNT - 1, CELL_COUNT - 2 * COLUMNS);
    if (r < 75) return $urandom_range(CELL_COUNT - 1);
    if (r < 88) return $urandom_range(4 * COLUMNS - 1);
    return $urandom_range(2047, CELL_COUNT);
  endfunction

  task automatic wait_sent();
    while (cmd_pend_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
  endtask

  // driver: predict on accept, then present the next word or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tuser <= '0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) console_expect_q.push_back(console_step(cur_cmd));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_cmd = cmd_pend_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= cur_cmd.op;
          s_axis_tdata <= {5'b0, cur_cmd.index, cur_cmd.fore, cur_cmd.back, cur_cmd.ch};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted word with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : monitor_b
    console_res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (console_expect_q.size() == 0) begin
          $display("%0t: unexpected word expected none actual %h", $time, m_axis_tdata);
          mismatch_count++;
        end else begin
          want = console_expect_q.pop_front();
          if (m_axis_tdata[10:0] !== want.pos) begin
            $display("%0t: cursor_position expected %0d actual %0d",
                     $time, want.pos, m_axis_tdata[10:0]);
            mismatch_count++;
          end
          if (m_axis_tdata[26:11] !== want.cdata) begin
            $display("%0t: cell_data expected %h actual %h",
                     $time, want.cdata, m_axis_tdata[26:11]);
            mismatch_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sel;
    int n;
    blank_shadow();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    push_op(OP_READ, 0);
    push_op(OP_READ, 2047);
    push_op(OP_READ, CELL_COUNT - 1);
    push_put(8'h41, 4'hF, 4'h0);
    push_put(CH_DEL, 4'h0, 4'hF);
    push_put(CH_SPACE, 4'hA, 4'h5);
    push_op(OP_READ, 0);
    push_op(OP_READ, 1);
    repeat (4) push_put(CH_BS, 4'h0, 4'h0);
    push_put(CH_TAB, 4'h0, 4'h0);
    push_put(8'h80, 4'hF, 4'hF);
    push_put(8'hFF, 4'hF, 4'hF);
    push_put(8'h00, 4'h0, 4'h0);
    push_put(8'h1F, 4'h0, 4'h0);
    push_put(CH_CR, 4'h0, 4'h0);
    push_put(CH_LF, 4'h0, 4'h0);
    push_op(OP_UNUSED, 2047);
    push_op(OP_CLEAR, 0);
    push_op(OP_READ, 0);
    wait_sent();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 55;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 55;
        end
        default: begin
          send_idle_pct = 10;
          recv_stall_pct = 10;
        end
      endcase
      stim_count = 0;
      while (stim_count < PHASE_WORDS) begin
        sel = $urandom_range(99);
        if (sel < 70) begin
          n = $urandom_range(12);
          for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            if (sel < 80) push_put(8'($urandom_range(CH_DEL, CH_SPACE)),
                                   4'($urandom_range(15)), 4'($urandom_range(15)));
            else if (sel < 88) push_put(CH_BS, 4'($urandom_range(15)),
                                        4'($urandom_range(15)));
            else if (sel < 96) push_put(CH_TAB, 4'($urandom_range(15)),
                                        4'($urandom_range(15)));
            else push_put(CH_CR, 4'($urandom_range(15)), 4'($urandom_range(15)));
          end
          if ($urandom_range(99) < 65) push_put(CH_LF, 4'($urandom_range(15)),
                                                4'($urandom_range(15)));
          repeat ($urandom_range(3)) push_op(OP_READ, pick_cell_index());
        end else if (sel < 78) begin
          repeat ($urandom_range(11, 5)) push_put(CH_TAB, 4'($urandom_range(15)),
                                                  4'($urandom_range(15)));
        end else if (sel < 86) begin
          repeat ($urandom_range(4, 1)) push_op(OP_READ, pick_cell_index());
        end else if (sel < 97) begin
          if ($urandom_range(3) == 0) push_op(OP_UNUSED, $urandom_range(2047));
          else push_put(8'($urandom_range(255)), 4'($urandom_range(15)),
                        4'($urandom_range(15)));
        end else begin
          push_op(OP_CLEAR, $urandom_range(2047));
        end
      end
      wait_sent();
    end

    while (console_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tmcw_pkg.sv
rtl/tmcw_screen_ram.sv
rtl/tmcw_cursor.sv
rtl/tmcw_ctrl.sv
rtl/text_mode_console_writer_top.sv
tb/sv/text_mode_console_writer_top_test.sv
